[hw/rtl/bcgd_pkg.sv]
package bcgd_pkg;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DBL_WINDOW = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 8'd1;

    // Reset values of the configuration registers, in milliseconds.
    localparam logic [15:0] DBL_WINDOW_RESET = 16'd400;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd1200;

    // Saturation value of the click counter.
    localparam logic [1:0] CLICKS_MAX = 2'd3;

    // Action codes reported per sample.
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_SINGLE = 2'd1,
        ACT_DOUBLE = 2'd2,
        ACT_LONG   = 2'd3
    } action_t;

    // Gesture tracking state carried from one sample to the next.
    typedef struct packed {
        logic        prev_level;
        logic [31:0] mark_time;
        logic        awaiting;
        logic [1:0]  clicks;
    } gesture_state_t;

    // Timing thresholds handed from the register block to the datapath.
    typedef struct packed {
        logic [15:0] dbl_window_ms;
        logic [15:0] long_press_ms;
    } cfg_t;

endpackage

[hw/rtl/bcgd_cfg.sv]
module bcgd_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bcgd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data,
    output bcgd_pkg::cfg_t                 cfg
);

    bcgd_pkg::cfg_t cfg_reg;

    // The register file can take a write transaction in every cycle.
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Threshold registers; writes to unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dbl_window_ms <= bcgd_pkg::DBL_WINDOW_RESET;
            cfg_reg.long_press_ms <= bcgd_pkg::LONG_PRESS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                bcgd_pkg::CFG_DBL_WINDOW: cfg_reg.dbl_window_ms <= cfg_data;
                bcgd_pkg::CFG_LONG_PRESS: cfg_reg.long_press_ms <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

[hw/rtl/bcgd_core.sv]
module bcgd_core (
    input  bcgd_pkg::gesture_state_t state_cur,
    input  bcgd_pkg::cfg_t           cfg,
    input  logic                     pin_level,
    input  logic [31:0]              now_ms,
    output bcgd_pkg::gesture_state_t state_upd,
    output bcgd_pkg::action_t        action
);

    logic        press_edge;
    logic        rel_edge;
    logic [31:0] held_ms;
    logic [31:0] idle_ms;

    // One sample: press edge, long-press test, release edge, single-click timeout.
    // Later checks override the action of earlier ones.
    always_comb begin
        state_upd  = state_cur;
        action     = bcgd_pkg::ACT_NONE;
        press_edge = !pin_level && state_cur.prev_level;
        rel_edge   = pin_level && !state_cur.prev_level;

        // A press records the time and counts a click, saturating.
        if (press_edge) begin
            state_upd.mark_time = now_ms;
            state_upd.awaiting  = 1'b1;
            if (state_upd.clicks != bcgd_pkg::CLICKS_MAX) begin
                state_upd.clicks = state_upd.clicks + 2'd1;
            end
        end

        // Held past the long-press threshold; the difference wraps mod 2^32.
        held_ms = now_ms - state_upd.mark_time;
        if (!pin_level && state_upd.awaiting &&
            (held_ms > {16'd0, cfg.long_press_ms})) begin
            state_upd.awaiting = 1'b0;
            state_upd.clicks   = 2'd0;
            action             = bcgd_pkg::ACT_LONG;
        end

        // Release after the first click restarts the window; after the second
        // it completes a double click.
        if (rel_edge) begin
            if (state_upd.clicks == 2'd1) begin
                state_upd.mark_time = now_ms;
            end else if (state_upd.clicks == 2'd2) begin
                state_upd.awaiting = 1'b0;
                state_upd.clicks   = 2'd0;
                action             = bcgd_pkg::ACT_DOUBLE;
            end
        end

        // Released long enough after a lone click: single click.
        idle_ms = now_ms - state_upd.mark_time;
        if (pin_level && state_upd.awaiting && (state_upd.clicks == 2'd1) &&
            (idle_ms > {16'd0, cfg.dbl_window_ms})) begin
            state_upd.awaiting = 1'b0;
            state_upd.clicks   = 2'd0;
            action             = bcgd_pkg::ACT_SINGLE;
        end

        state_upd.prev_level = pin_level;
    end

endmodule

[hw/rtl/button_click_gesture_detector.sv]
// Button click gesture detector. Each input transaction carries one sample of an
// active-low button (s_pin_level, 0 = pressed) and a free-running millisecond
// timestamp (s_now_ms); each produces exactly one output transaction with an
// action code on m_action: none, single click, double click or long press.
// The block takes one sample per clock cycle unless the result side stalls; each
// sample passes through the input register and then the result register, with
// the gesture evaluation between them. Back-pressure on the result side holds
// the input register and then s_ready. Thresholds are written through the cfg_
// channel (index 0: double-click window, index 1: long-press time, both in
// milliseconds) and should only change while no sample is pending.
module button_click_gesture_detector (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_pin_level,
    input  logic [31:0]                    s_now_ms,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_action,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bcgd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data
);

    bcgd_pkg::cfg_t           cfg;
    bcgd_pkg::gesture_state_t state_reg;
    bcgd_pkg::gesture_state_t state_next;
    bcgd_pkg::action_t        action_next;

    logic        in_valid_reg;
    logic        in_level_reg;
    logic [31:0] in_now_reg;
    logic        out_valid_reg;
    logic [1:0]  out_action_reg;
    logic        advance;

    bcgd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcgd_core u_core (
        .state_cur (state_reg),
        .cfg       (cfg),
        .pin_level (in_level_reg),
        .now_ms    (in_now_reg),
        .state_upd (state_next),
        .action    (action_next)
    );

    // The sample moves on when the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign m_valid  = out_valid_reg;
    assign m_action = out_action_reg;

    // Input register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_level_reg <= s_pin_level;
            in_now_reg   <= s_now_ms;
        end
    end

    // Gesture state and result register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.prev_level <= 1'b1;
            state_reg.mark_time  <= 32'd0;
            state_reg.awaiting   <= 1'b0;
            state_reg.clicks     <= 2'd0;
            out_valid_reg        <= 1'b0;
        end else begin
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_action_reg <= action_next;
        end
    end

endmodule

[hw/rtl/bcgd_checker.sv]
module bcgd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_action
);

    // No result is offered in the cycle after reset.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result holds its action code.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_action))
        else $error("stalled result changed");

    // With the result side draining, the input side never stalls.
    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output ready");

    // Every accepted sample is later followed by a result offered (m_valid high).
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##2 m_valid)
        else $error("result missing two cycles after a transaction");

endmodule

bind button_click_gesture_detector bcgd_checker u_bcgd_checker (.*);

[bench/tb_button_click_gesture_detector.sv]
`timescale 1ns / 100ps

module tb_button_click_gesture_detector;

    import bcgd_pkg::*;

    // Index values that map to no register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_INDEX   = 8'hFF;

    localparam int NUM_PHASES     = 8;
    localparam int SAMPLES_PER_PHASE = 190;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DUT_LATENCY    = 2;

    typedef struct packed {
        logic        level;
        logic [31:0] now_ms;
    } button_sample_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_pin_level;
    logic [31:0]          s_now_ms;
    logic                 m_valid;
    logic                 m_ready;
    logic [1:0]           m_action;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    // Samples waiting to be sent and actions waiting to be seen.
    button_sample_t pending_samples[$];
    action_t        expected_actions[$];

    // Predicted gesture state and the thresholds the block should be using.
    gesture_state_t gesture;
    cfg_t           thresholds;

    logic [31:0] stamp_ms;
    logic        no_idle;
    int          send_wait;
    int          recv_wait;
    int          idle_cycles;
    int          samples_queued;
    int          samples_accepted;
    int          results_seen;
    int          mismatches;
    int          register_writes;
    int          action_tally[4];
    logic [15:0] window_plan[NUM_PHASES];
    logic [15:0] long_plan[NUM_PHASES];

    button_click_gesture_detector u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pin_level (s_pin_level),
        .s_now_ms    (s_now_ms),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_action    (m_action),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Free-running 100 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // Works out the action for one sample and advances the predicted state.
    // Checks run in the order press, long hold, release, single-click timeout.
    function automatic action_t predict_action(input logic level, input logic [31:0] now);
        action_t     act;
        logic [31:0] elapsed;
        act = ACT_NONE;
        if (!level && gesture.prev_level) begin
            gesture.mark_time = now;
            gesture.awaiting  = 1'b1;
            if (gesture.clicks != CLICKS_MAX)
                gesture.clicks = gesture.clicks + 2'd1;
        end
        elapsed = now - gesture.mark_time;
        if (!level && gesture.awaiting && elapsed > {16'd0, thresholds.long_press_ms}) begin
            gesture.awaiting = 1'b0;
            gesture.clicks   = 2'd0;
            act = ACT_LONG;
        end
        if (level && !gesture.prev_level) begin
            if (gesture.clicks == 2'd1) begin
                gesture.mark_time = now;
            end else if (gesture.clicks == 2'd2) begin
                gesture.awaiting = 1'b0;
                gesture.clicks   = 2'd0;
                act = ACT_DOUBLE;
            end
        end
        elapsed = now - gesture.mark_time;
        if (level && gesture.awaiting && gesture.clicks == 2'd1 &&
            elapsed > {16'd0, thresholds.dbl_window_ms}) begin
            gesture.awaiting = 1'b0;
            gesture.clicks   = 2'd0;
            act = ACT_SINGLE;
        end
        gesture.prev_level = level;
        return act;
    endfunction

    // Time step chosen around a threshold, so that both sides of it get hit.
    function automatic logic [31:0] pick_interval(input logic [15:0] thr);
        logic [31:0] t;
        t = {16'd0, thr};
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1);
            1: return t;
            2: return t + 32'd1;
            3: return (t == 0) ? 32'd0 : t - 32'd1;
            4: return $urandom_range(0, t);
            default: return $urandom_range(0, t / 2);
        endcase
    endfunction

    task automatic queue_sample(input logic level, input logic [31:0] now);
        pending_samples.push_back('{level: level, now_ms: now});
        samples_queued++;
    endtask

    task automatic advance_and_queue(input logic level, input logic [31:0] dt);
        stamp_ms = stamp_ms + dt;
        queue_sample(level, stamp_ms);
    endtask

    // One gesture with random timing: a single, double, long or repeated
    // press, or a short burst of noise with arbitrary levels and times.
    task automatic queue_gesture();
        int kind;
        int presses;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 6))
                queue_sample(1'($urandom_range(0, 1)), $urandom);
        end else begin
            presses = (kind <= 4) ? 1 : (kind <= 7) ? 2 : 3;
            for (int i = 0; i < presses; i++) begin
                advance_and_queue(1'b0, pick_interval(thresholds.dbl_window_ms));
                repeat ($urandom_range(0, 2))
                    advance_and_queue(1'b0, pick_interval(thresholds.long_press_ms) / 2);
                if (kind == 4 && i == 0)
                    advance_and_queue(1'b0,
                        {16'd0, thresholds.long_press_ms} + 32'd1 + $urandom_range(0, 3));
                advance_and_queue(1'b1, pick_interval(thresholds.long_press_ms));
            end
            repeat ($urandom_range(1, 3))
                advance_and_queue(1'b1, pick_interval(thresholds.dbl_window_ms));
        end
    endtask

    // Blocks until every queued sample is accepted and its action checked.
    task automatic wait_for_results();
        do
            @(posedge aclk);
        while (samples_accepted != samples_queued || expected_actions.size() != 0);
        repeat (DUT_LATENCY + 2) @(posedge aclk);
    endtask

    // Single register write transaction; the predicted thresholds follow it.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_DBL_WINDOW)
            thresholds.dbl_window_ms = value;
        else if (idx == CFG_LONG_PRESS)
            thresholds.long_press_ms = value;
        register_writes++;
    endtask

    // Sample driver: presents queued samples, with a random gap after each one.
    always @(posedge aclk) begin : drive_samples
        button_sample_t next_sample;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_wait <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_actions.push_back(predict_action(s_pin_level, s_now_ms));
                samples_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (send_wait != 0) begin
                    send_wait <= send_wait - 1;
                    s_valid   <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    next_sample = pending_samples.pop_front();
                    s_valid     <= 1'b1;
                    s_pin_level <= next_sample.level;
                    s_now_ms    <= next_sample.now_ms;
                    send_wait   <= no_idle ? 0 : $urandom_range(0, 9);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each action transaction and stalls at random.
    always @(posedge aclk) begin : check_results
        int      stall;
        action_t want;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait <= 0;
        end else begin
            stall = recv_wait;
            if (m_valid && m_ready) begin
                if (expected_actions.size() == 0) begin
                    report_mismatch($sformatf("action %0d arrived with nothing expected",
                                              m_action));
                end else begin
                    want = expected_actions.pop_front();
                    action_tally[want]++;
                    if (m_action !== want)
                        report_mismatch($sformatf("result %0d: action %0d, expected %s",
                                                  results_seen, m_action, want.name()));
                end
                results_seen++;
                stall = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (stall != 0) begin
                m_ready   <= 1'b0;
                recv_wait <= stall - 1;
            end else begin
                m_ready   <= 1'b1;
                recv_wait <= 0;
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any transaction.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Main sequence: reset, directed samples, then one random phase per setting.
    initial begin
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_pin_level      = 1'b1;
        s_now_ms         = '0;
        m_ready          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        no_idle          = 1'b0;
        idle_cycles      = 0;
        samples_queued   = 0;
        samples_accepted = 0;
        results_seen     = 0;
        mismatches       = 0;
        register_writes  = 0;
        action_tally     = '{default: 0};
        gesture          = '{prev_level: 1'b1, mark_time: 32'd0, awaiting: 1'b0, clicks: 2'd0};
        thresholds       = '{dbl_window_ms: DBL_WINDOW_RESET, long_press_ms: LONG_PRESS_RESET};
        window_plan = '{16'd400, 16'd1, 16'd65535, 16'd0, 16'd65535, 16'd1, 16'd0, 16'd400};
        long_plan   = '{16'd1200, 16'd1, 16'd65535, 16'd0, 16'd1, 16'd65535, 16'd0, 16'd1200};
        window_plan[6] = 16'($urandom_range(1, 65535));
        long_plan[6]   = 16'($urandom_range(1, 65535));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed samples at the reset thresholds.
        // A release with no click in progress, then a long press just past the limit.
        queue_sample(1'b1, 32'd0);
        queue_sample(1'b0, 32'd100);
        queue_sample(1'b0, 32'd1300);
        queue_sample(1'b0, 32'd1301);
        queue_sample(1'b1, 32'd1400);
        // Single click: released exactly at the window, then one past it.
        queue_sample(1'b0, 32'd2000);
        queue_sample(1'b1, 32'd2100);
        queue_sample(1'b1, 32'd2500);
        queue_sample(1'b1, 32'd2501);
        // Double click.
        queue_sample(1'b0, 32'd3000);
        queue_sample(1'b1, 32'd3050);
        queue_sample(1'b0, 32'd3100);
        queue_sample(1'b1, 32'd3150);
        // Long press across the timestamp wrap.
        queue_sample(1'b0, 32'hFFFF_FF00);
        queue_sample(1'b0, 32'h0000_0300);
        queue_sample(1'b0, 32'h0000_0400);
        queue_sample(1'b1, 32'h0000_0500);
        // Press at the largest timestamp, single click timed out after the wrap.
        queue_sample(1'b0, 32'hFFFF_FFFF);
        queue_sample(1'b1, 32'h0000_0000);
        queue_sample(1'b1, 32'h0000_0190);
        queue_sample(1'b1, 32'h0000_0191);
        wait_for_results();

        for (int phase = 1; phase < NUM_PHASES; phase++) begin
            write_register(CFG_DBL_WINDOW, window_plan[phase]);
            write_register(CFG_LONG_PRESS, long_plan[phase]);
            if (phase == NUM_PHASES - 1) begin
                write_register(CFG_SPARE_INDEX, 16'($urandom));
                write_register(CFG_TOP_INDEX, 16'($urandom));
            end
            no_idle  = (phase % 3 == 2);
            stamp_ms = $urandom;
            begin
                int phase_start;
                phase_start = samples_queued;
                while (samples_queued - phase_start < SAMPLES_PER_PHASE) begin
                    queue_gesture();
                    // Now and then hold the sender until every action is back.
                    if ($urandom_range(0, 29) == 0)
                        wait_for_results();
                end
            end
            wait_for_results();
        end

        if (expected_actions.size() != 0)
            report_mismatch($sformatf("%0d actions never arrived", expected_actions.size()));

        $display("Checked %0d samples over %0d threshold settings with %0d register writes.",
                 results_seen, NUM_PHASES, register_writes);
        $display("Actions seen: %0d none, %0d single, %0d double, %0d long; %0d mismatches.",
                 action_tally[ACT_NONE], action_tally[ACT_SINGLE], action_tally[ACT_DOUBLE],
                 action_tally[ACT_LONG], mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
